// ===== rtl/core/etq_pkg.sv =====
// Shared types and constants for the escaped/quoted tokenizer.
`default_nettype none

package etq_pkg;

    // Default slot counts for the character sets
    localparam int DELIM_SLOTS_DEF  = 4;
    localparam int ESCAPE_SLOTS_DEF = 2;
    localparam int QUOTE_SLOTS_DEF  = 2;

    // Register file
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_SET   = 3'd0,
        CFG_DELIM_SLOTS = 3'd1,
        CFG_ESC_SET     = 3'd2,
        CFG_ESC_SLOTS   = 3'd3,
        CFG_QUOTE_SET   = 3'd4,
        CFG_QUOTE_SLOTS = 3'd5
    } cfg_idx_t;

    localparam int DELIM_CNT_W = 3;
    localparam int ESC_CNT_W   = 2;
    localparam int QUOTE_CNT_W = 2;

    localparam logic [7:0] DELIM_CHAR_RST = 8'd32;  // space
    localparam logic [7:0] ESC_CHAR_RST   = 8'd92;  // backslash
    localparam logic [7:0] QUOTE_CHAR_RST = 8'd34;  // double quote

    localparam logic [DELIM_CNT_W-1:0] DELIM_CNT_RST = 3'd1;
    localparam logic [ESC_CNT_W-1:0]   ESC_CNT_RST   = 2'd1;
    localparam logic [QUOTE_CNT_W-1:0] QUOTE_CNT_RST = 2'd1;

    // Queue between classifier and token engine
    localparam int QUEUE_DEPTH = 2;

    // Classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       is_esc;
        logic       is_quote;
        logic       is_delim;
    } etq_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/etq_front.sv =====
// Front end: configuration registers and byte classification.
`default_nettype none

module etq_front #(
    parameter int DELIM_SLOTS  = 4,
    parameter int ESCAPE_SLOTS = 2,
    parameter int QUOTE_SLOTS  = 2,
    parameter int CFG_W        = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [etq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    in_char,
    input  wire logic                          string_end,
    input  wire logic                          q_full,
    output logic                               q_push,
    output etq_pkg::etq_item_t                 q_item
);
    import etq_pkg::*;

    localparam int DW = 8 * DELIM_SLOTS;
    localparam int EW = 8 * ESCAPE_SLOTS;
    localparam int QW = 8 * QUOTE_SLOTS;

    logic [DW-1:0]          delim_set_reg;
    logic [DELIM_CNT_W-1:0] delim_cnt_reg;
    logic [EW-1:0]          esc_set_reg;
    logic [ESC_CNT_W-1:0]   esc_cnt_reg;
    logic [QW-1:0]          quote_set_reg;
    logic [QUOTE_CNT_W-1:0] quote_cnt_reg;

    logic hit_esc;
    logic hit_quote;
    logic hit_delim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_set_reg <= {{(DW-8){1'b0}}, DELIM_CHAR_RST};
            delim_cnt_reg <= DELIM_CNT_RST;
            esc_set_reg   <= {{(EW-8){1'b0}}, ESC_CHAR_RST};
            esc_cnt_reg   <= ESC_CNT_RST;
            quote_set_reg <= {{(QW-8){1'b0}}, QUOTE_CHAR_RST};
            quote_cnt_reg <= QUOTE_CNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DELIM_SET:   delim_set_reg <= cfg_wdata[DW-1:0];
                CFG_DELIM_SLOTS: delim_cnt_reg <= cfg_wdata[DELIM_CNT_W-1:0];
                CFG_ESC_SET:     esc_set_reg   <= cfg_wdata[EW-1:0];
                CFG_ESC_SLOTS:   esc_cnt_reg   <= cfg_wdata[ESC_CNT_W-1:0];
                CFG_QUOTE_SET:   quote_set_reg <= cfg_wdata[QW-1:0];
                CFG_QUOTE_SLOTS: quote_cnt_reg <= cfg_wdata[QUOTE_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // A slot counts only below the programmed count; larger counts saturate
    // naturally at the slot parameter.
    always_comb
    begin
        hit_esc   = 1'b0;
        hit_quote = 1'b0;
        hit_delim = 1'b0;
        for (int i = 0; i < ESCAPE_SLOTS; i++)
        begin
            if (i < int'(esc_cnt_reg) && esc_set_reg[8*i +: 8] == in_char)
                hit_esc = 1'b1;
        end
        for (int i = 0; i < QUOTE_SLOTS; i++)
        begin
            if (i < int'(quote_cnt_reg) && quote_set_reg[8*i +: 8] == in_char)
                hit_quote = 1'b1;
        end
        for (int i = 0; i < DELIM_SLOTS; i++)
        begin
            if (i < int'(delim_cnt_reg) && delim_set_reg[8*i +: 8] == in_char)
                hit_delim = 1'b1;
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Priority: escape, then quote, then delimiter
    assign q_item.ch       = in_char;
    assign q_item.last     = string_end;
    assign q_item.is_esc   = hit_esc;
    assign q_item.is_quote = !hit_esc && hit_quote;
    assign q_item.is_delim = !hit_esc && !hit_quote && hit_delim;

endmodule

`default_nettype wire

// ===== rtl/core/etq_queue.sv =====
// Short queue of classified bytes between front and back.
`default_nettype none

module etq_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire etq_pkg::etq_item_t push_item,
    output logic                    full,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output etq_pkg::etq_item_t      pop_item
);
    import etq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    etq_item_t         mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/etq_back.sv =====
// Back end: token state machine and output register.
`default_nettype none

module etq_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire etq_pkg::etq_item_t q_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_char,
    output logic                    char_valid,
    output logic                    token_end
);
    import etq_pkg::*;

    logic in_escape_reg, in_escape_next;
    logic in_quote_reg,  in_quote_next;
    logic open_reg,      open_next;
    logic seen_reg,      seen_next;

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       char_valid_reg;
    logic       token_end_reg;

    logic take;
    logic emit;
    logic fin;

    assign q_ready = !out_valid_reg || out_ready;
    assign take    = q_valid && q_ready;

    always_comb
    begin
        in_escape_next = in_escape_reg;
        in_quote_next  = in_quote_reg;
        open_next      = open_reg;
        seen_next      = seen_reg;
        emit           = 1'b0;
        fin            = 1'b0;

        // Leading or repeated delimiters outside a token are skipped
        if (open_reg || !q_item.is_delim)
        begin
            open_next = 1'b1;
            seen_next = 1'b1;
            if (q_item.is_esc)
            begin
                if (in_escape_reg)
                begin
                    emit           = 1'b1;
                    in_escape_next = 1'b0;
                end
                else
                begin
                    emit           = in_quote_reg;
                    in_escape_next = 1'b1;
                end
            end
            else if (q_item.is_quote)
            begin
                if (in_escape_reg)
                begin
                    emit           = 1'b1;
                    in_escape_next = 1'b0;
                end
                else
                    in_quote_next = !in_quote_reg;
            end
            else if (q_item.is_delim)
            begin
                if (in_escape_reg || in_quote_reg)
                begin
                    emit           = 1'b1;
                    in_escape_next = 1'b0;
                end
                else
                begin
                    fin       = 1'b1;
                    open_next = 1'b0;
                end
            end
            else
            begin
                emit           = 1'b1;
                in_escape_next = 1'b0;
            end
        end

        // String end closes an open token, or gives the empty token when
        // nothing was opened at all.
        if (q_item.last)
        begin
            if (open_next || !seen_next)
                fin = 1'b1;
            in_escape_next = 1'b0;
            in_quote_next  = 1'b0;
            open_next      = 1'b0;
            seen_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_escape_reg <= 1'b0;
            in_quote_reg  <= 1'b0;
            open_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
                out_valid_reg <= 1'b0;
            if (take)
            begin
                in_escape_reg <= in_escape_next;
                in_quote_reg  <= in_quote_next;
                open_reg      <= open_next;
                seen_reg      <= seen_next;
                if (emit || fin)
                    out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (emit || fin))
        begin
            out_char_reg   <= emit ? q_item.ch : 8'd0;
            char_valid_reg <= emit;
            token_end_reg  <= fin;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign char_valid = char_valid_reg;
    assign token_end  = token_end_reg;

endmodule

`default_nettype wire

// ===== rtl/core/escaped_quoted_tokeniser.sv =====
// Top level of the escaped/quoted delimiter tokenizer.
//
// Input channel (in_valid/in_ready): one beat per string byte, in_char plus
// string_end on the final byte. Output channel (out_valid/out_ready): zero or
// one beat per input byte, carrying out_char/char_valid/token_end; out_char is
// zero when char_valid is low. A beat may carry a byte and a token end at once.
// Throughput: one byte per cycle while the queue has room and the output does
// not stall. An accepted byte is written into the queue, then taken from the
// queue into the output register, which presents its result. Configuration:
// cfg_we/cfg_index/cfg_wdata write one register per edge. The user must write
// only while no byte is in flight; the block itself does not enforce this.
// Indexes: delimiter set, delimiter slots, escape set, escape slots, quote
// set, quote slots; others are ignored.
// Reset: sets revert to space, backslash and double quote with one slot each;
// all token state and the queue clear. When out_ready is low the output beat
// holds; the queue keeps taking bytes until it fills, then in_ready drops.
`default_nettype none

module escaped_quoted_tokeniser #(
    parameter int DELIM_SLOTS  = etq_pkg::DELIM_SLOTS_DEF,
    parameter int ESCAPE_SLOTS = etq_pkg::ESCAPE_SLOTS_DEF,
    parameter int QUOTE_SLOTS  = etq_pkg::QUOTE_SLOTS_DEF,
    localparam int CFG_W = 8 * ((DELIM_SLOTS >= ESCAPE_SLOTS && DELIM_SLOTS >= QUOTE_SLOTS)
                                ? DELIM_SLOTS
                                : ((ESCAPE_SLOTS >= QUOTE_SLOTS) ? ESCAPE_SLOTS
                                                                 : QUOTE_SLOTS))
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [etq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    in_char,
    input  wire logic                          string_end,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         out_char,
    output logic                               char_valid,
    output logic                               token_end
);
    import etq_pkg::*;

    logic      q_full;
    logic      q_push;
    etq_item_t push_item;
    logic      q_valid;
    logic      q_ready;
    etq_item_t pop_item;

    etq_front #(
        .DELIM_SLOTS  (DELIM_SLOTS),
        .ESCAPE_SLOTS (ESCAPE_SLOTS),
        .QUOTE_SLOTS  (QUOTE_SLOTS),
        .CFG_W        (CFG_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .string_end (string_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    etq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_item  (pop_item)
    );

    etq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .char_valid (char_valid),
        .token_end  (token_end)
    );

    // No empty result beats
    a_beat_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_valid || token_end))
        else $error("result beat with neither byte nor token end");

    // Unused byte field reads zero
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !char_valid) |-> (out_char == 8'd0))
        else $error("out_char nonzero without char_valid");

    // Nothing is presented once reset has been seen at an edge
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("out_valid during reset");

endmodule

`default_nettype wire

// ===== dv/escaped_quoted_tokeniser_tb.sv =====
// Testbench for the escaped/quoted tokenizer: directed and random strings against a scoreboard.
`timescale 1ns / 100ps

module escaped_quoted_tokeniser_tb;
    import etq_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       te;
    } token_beat_t;

    class token_scoreboard;
        logic [31:0] delim_set;
        logic [2:0]  delim_slots;
        logic [15:0] esc_set;
        logic [1:0]  esc_slots;
        logic [15:0] quote_set;
        logic [1:0]  quote_slots;
        bit in_escape;
        bit in_quote;
        bit token_open;
        bit token_seen;
        token_beat_t expected_beats[$];
        int errors;

        function new();
            delim_set   = {24'd0, DELIM_CHAR_RST};
            delim_slots = DELIM_CNT_RST;
            esc_set     = {8'd0, ESC_CHAR_RST};
            esc_slots   = ESC_CNT_RST;
            quote_set   = {8'd0, QUOTE_CHAR_RST};
            quote_slots = QUOTE_CNT_RST;
            in_escape   = 1'b0;
            in_quote    = 1'b0;
            token_open  = 1'b0;
            token_seen  = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                CFG_DELIM_SET:   delim_set   = value;
                CFG_DELIM_SLOTS: delim_slots = value[2:0];
                CFG_ESC_SET:     esc_set     = value[15:0];
                CFG_ESC_SLOTS:   esc_slots   = value[1:0];
                CFG_QUOTE_SET:   quote_set   = value[15:0];
                CFG_QUOTE_SLOTS: quote_slots = value[1:0];
                default: ;
            endcase
        endfunction

        // counts above the slot parameter saturate, zero disables the set
        static function bit hits_set(logic [31:0] set_bytes, int count, int limit,
                                     logic [7:0] c);
            int n;
            n = (count > limit) ? limit : count;
            for (int i = 0; i < n; i++)
                if (set_bytes[8*i +: 8] == c)
                    return 1'b1;
            return 1'b0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            bit is_esc;
            bit is_quote;
            bit is_delim;
            bit emit;
            bit ends;
            token_beat_t beat;
            is_esc   = hits_set({16'd0, esc_set}, esc_slots, ESCAPE_SLOTS_DEF, c);
            is_quote = !is_esc &&
                       hits_set({16'd0, quote_set}, quote_slots, QUOTE_SLOTS_DEF, c);
            is_delim = !is_esc && !is_quote &&
                       hits_set(delim_set, delim_slots, DELIM_SLOTS_DEF, c);
            emit = 1'b0;
            ends = 1'b0;
            if (token_open || !is_delim)
            begin
                token_open = 1'b1;
                token_seen = 1'b1;
                if (is_esc)
                begin
                    if (in_escape)
                    begin
                        emit = 1'b1;
                        in_escape = 1'b0;
                    end
                    else
                    begin
                        emit = in_quote;
                        in_escape = 1'b1;
                    end
                end
                else if (is_quote)
                begin
                    if (in_escape)
                    begin
                        emit = 1'b1;
                        in_escape = 1'b0;
                    end
                    else
                        in_quote = !in_quote;
                end
                else if (is_delim)
                begin
                    if (in_escape || in_quote)
                    begin
                        emit = 1'b1;
                        in_escape = 1'b0;
                    end
                    else
                    begin
                        ends = 1'b1;
                        token_open = 1'b0;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    in_escape = 1'b0;
                end
            end
            if (last)
            begin
                if (token_open || !token_seen)
                    ends = 1'b1;
                in_escape  = 1'b0;
                in_quote   = 1'b0;
                token_open = 1'b0;
                token_seen = 1'b0;
            end
            if (emit || ends)
            begin
                beat.ch = emit ? c : 8'd0;
                beat.cv = emit;
                beat.te = ends;
                expected_beats = {expected_beats, beat};
            end
        endfunction

        function void check_beat(logic [7:0] ch, logic cv, logic te);
            token_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: out_char=%0h char_valid=%0b token_end=%0b",
                       ch, cv, te);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (ch !== want.ch)
            begin
                $error("out_char: expected %0h, got %0h", want.ch, ch);
                errors++;
            end
            if (cv !== want.cv)
            begin
                $error("char_valid: expected %0b, got %0b", want.cv, cv);
                errors++;
            end
            if (te !== want.te)
            begin
                $error("token_end: expected %0b, got %0b", want.te, te);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           in_char = '0;
    logic                 string_end = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           out_char;
    logic                 char_valid;
    logic                 token_end;

    token_scoreboard sb;
    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int rx_hold_req = 0;
    int cycle_count = 0;

    escaped_quoted_tokeniser u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .string_end (string_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .char_valid (char_valid),
        .token_end  (token_end)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("escaped_quoted_tokeniser verification failed");
            $finish;
        end
    end

    // Output side: random stall per beat, or one long hold when requested
    initial
    begin : rx_side
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, rx_gap_max);
            if (rx_hold_req > 0)
            begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_beat(out_char, char_valid, token_end);
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_char    <= c;
        string_end <= last;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_byte(c, last);
    endtask

    // call right after an accepted beat
    task automatic tx_stop();
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        // a trailing byte may produce nothing yet still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // bias toward bytes of the active sets so every class shows up often
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)
            return sb.delim_set[8*$urandom_range(0, 3) +: 8];
        else if (r < 36)
            return sb.esc_set[8*$urandom_range(0, 1) +: 8];
        else if (r < 50)
            return sb.quote_set[8*$urandom_range(0, 1) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    send_byte(pick_char(), i == len - 1);
                sent += len;
            end
        end
    endtask

    task automatic cfg_random();
        write_cfg(CFG_DELIM_SET, $urandom());
        write_cfg(CFG_DELIM_SLOTS, $urandom());
        write_cfg(CFG_ESC_SET, $urandom());
        write_cfg(CFG_ESC_SLOTS, $urandom());
        write_cfg(CFG_QUOTE_SET, $urandom());
        write_cfg(CFG_QUOTE_SLOTS, $urandom());
    endtask

    initial
    begin : main_seq
        logic [7:0] shared_b;
        logic [7:0] shared_q;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sets: space, backslash, double quote
        tx_gap_max = 3;
        rx_gap_max = 3;
        send_text(" a  b");
        send_text("  ");
        send_text("\\\"\\\\\\ ");
        send_text("\"a \\x\"");
        send_text("\"z\\");
        send_text("b  ");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        tx_stop();
        drain();

        // all sets disabled: every byte is literal, so the block fills under a hold
        write_cfg(CFG_DELIM_SLOTS, 32'd0);
        write_cfg(CFG_ESC_SLOTS, 32'd0);
        write_cfg(CFG_QUOTE_SLOTS, 32'd0);
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_req = LONG_HOLD;
        for (int i = 0; i < 30; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        tx_stop();
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    // oversized counts, upper bits set
                    write_cfg(CFG_DELIM_SET, 32'hFFFF_FFFF);
                    write_cfg(CFG_DELIM_SLOTS, 32'hFFFF_FFFF);
                    write_cfg(CFG_ESC_SET, $urandom());
                    write_cfg(CFG_ESC_SLOTS, 32'hFFFF_FFFF);
                    write_cfg(CFG_QUOTE_SET, $urandom());
                    write_cfg(CFG_QUOTE_SLOTS, 32'hFFFF_FFFF);
                end
                1:
                begin
                    // one byte in all three sets, another in quote and delimiter sets
                    shared_b = 8'($urandom_range(0, 255));
                    shared_q = shared_b ^ 8'h5A;
                    write_cfg(CFG_DELIM_SET, {16'($urandom()), shared_q, shared_b});
                    write_cfg(CFG_DELIM_SLOTS, 32'd4);
                    write_cfg(CFG_ESC_SET, {16'($urandom()), 8'($urandom()), shared_b});
                    write_cfg(CFG_ESC_SLOTS, 32'd2);
                    write_cfg(CFG_QUOTE_SET, {16'($urandom()), shared_q, shared_b});
                    write_cfg(CFG_QUOTE_SLOTS, 32'd2);
                end
                2:
                begin
                    write_cfg(CFG_DELIM_SET, 32'd0);
                    write_cfg(CFG_ESC_SET, 32'd0);
                    write_cfg(CFG_QUOTE_SET, 32'hFFFF_0000);
                    write_cfg(CFG_DELIM_SLOTS, 32'd1);
                    write_cfg(CFG_ESC_SLOTS, 32'd1);
                    write_cfg(CFG_QUOTE_SLOTS, 32'd2);
                end
                5:
                begin
                    cfg_random();
                    write_cfg(CFG_IDX_SPARE, $urandom());
                end
                7:
                begin
                    write_cfg(CFG_DELIM_SET, {24'd0, DELIM_CHAR_RST});
                    write_cfg(CFG_DELIM_SLOTS, 32'(DELIM_CNT_RST));
                    write_cfg(CFG_ESC_SET, {24'd0, ESC_CHAR_RST});
                    write_cfg(CFG_ESC_SLOTS, 32'(ESC_CNT_RST));
                    write_cfg(CFG_QUOTE_SET, {24'd0, QUOTE_CHAR_RST});
                    write_cfg(CFG_QUOTE_SLOTS, 32'(QUOTE_CNT_RST));
                end
                default: cfg_random();
            endcase
            tx_gap_max = (p % 3 == 0) ? 0 : 12;
            rx_gap_max = (p % 3 == 2) ? 0 : 12;
            if (p == 4)
            begin
                run_random(22);
                // sender holds until the output side has caught up
                tx_stop();
                do @(posedge clk); while (sb.pending() != 0);
                run_random(23);
            end
            else
                run_random(45);
            tx_stop();
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("escaped_quoted_tokeniser verification clean");
        else
            $display("escaped_quoted_tokeniser verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/etq_pkg.sv
rtl/core/etq_front.sv
rtl/core/etq_queue.sv
rtl/core/etq_back.sv
rtl/core/escaped_quoted_tokeniser.sv
dv/escaped_quoted_tokeniser_tb.sv
